// File: sv/sun_position_from_day_assert.svh
// assertion macros for the sun position block
`ifndef SUN_POSITION_FROM_DAY_ASSERT_SVH
`define SUN_POSITION_FROM_DAY_ASSERT_SVH

// implication checked on every rising clock edge out of reset
`define SPD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sun position check failed");

// condition that must never be seen out of reset
`define SPD_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("sun position check failed");

`endif

// File: sv/spd_pkg.sv
package spd_pkg;

    // default number of rotation stages
    localparam int CORDIC_STAGES_DEF = 24;

    // day and time constants, signed: DAY_OFS in Q16, K_T in Q56, ONE40 in Q40
    localparam logic signed [63:0] DAY_OFS = 64'sd98304;
    localparam logic signed [63:0] K_T     = (64'd54757 << 46) / 64'd1953125;
    localparam logic signed [63:0] ONE40   = 64'sd1 << 40;

    // mean longitude polynomial, turns
    localparam logic signed [63:0] L0C = (64'd5609329 << 40) / 64'd7200000;
    localparam logic signed [63:0] L1C = (64'd100 << 40) + (64'd76983 << 40) / 64'd36000000;
    localparam logic signed [63:0] L2C = (64'd3032 << 40) / 64'd3600000000;

    // mean anomaly polynomial, turns
    localparam logic signed [63:0] M0C = (64'd3575291 << 40) / 64'd3600000;
    localparam logic signed [63:0] M1C = (64'd99 << 40) + (64'd3590503 << 40) / 64'd3600000;
    localparam logic signed [63:0] M2C = (64'd1559 << 40) / 64'd3600000000;
    localparam logic signed [63:0] M3C = (64'd1 << 40) / 64'd750000000;

    // equation of centre amplitudes, turns
    localparam logic signed [63:0] EQ_A0 = (64'd9573 << 40) / 64'd1800000;
    localparam logic signed [63:0] EQ_A1 = (64'd4817 << 40) / 64'd360000000;
    localparam logic signed [63:0] EQ_A2 = (64'd14 << 40) / 64'd360000000;
    localparam logic signed [63:0] EQ_B0 = (64'd1993 << 40) / 64'd36000000;
    localparam logic signed [63:0] EQ_B1 = (64'd101 << 40) / 64'd360000000;
    localparam logic signed [63:0] EQ_C0 = (64'd29 << 40) / 64'd36000000;

    // eccentricity and semi-major axis
    localparam logic signed [63:0] ECC0 = (64'd16708617 << 31) / 64'd1953125;
    localparam logic signed [63:0] ECC1 = (64'd42037 << 31) / 64'd1953125;
    localparam logic signed [63:0] ECC2 = (64'd1236 << 30) / 64'd9765625;
    localparam logic signed [63:0] SEMI = (64'sd1 << 40) + (64'd1018 << 31) / 64'd1953125;

    // rotation constants
    localparam logic [63:0]        INV2PI_Q64      = 64'h28BE_60DB_9391_054A;
    localparam logic signed [63:0] CORDIC_GAIN_INV = 64'sh26DD_3B6A;

    // partial products of a sign-magnitude 64x64 multiply
    typedef struct packed {
        logic        neg;
        logic [63:0] p3;
        logic [63:0] p2;
        logic [63:0] p1;
        logic [63:0] p0;
    } t_mul_pp;

    // first half: magnitudes and four 32x32 products
    function automatic t_mul_pp mul_pp(input logic signed [63:0] a,
                                       input logic signed [63:0] b);
        logic [63:0] ua;
        logic [63:0] ub;
        t_mul_pp     p;
        ua    = a[63] ? (64'd0 - $unsigned(a)) : $unsigned(a);
        ub    = b[63] ? (64'd0 - $unsigned(b)) : $unsigned(b);
        p.neg = a[63] ^ b[63];
        p.p0  = 64'(ua[31:0]) * 64'(ub[31:0]);
        p.p1  = 64'(ua[31:0]) * 64'(ub[63:32]);
        p.p2  = 64'(ua[63:32]) * 64'(ub[31:0]);
        p.p3  = 64'(ua[63:32]) * 64'(ub[63:32]);
        return p;
    endfunction

    // second half: sum, shift, clamp magnitude, restore sign
    function automatic logic signed [63:0] mul_fin(input t_mul_pp p, input int unsigned sh);
        logic [127:0] prod;
        logic [63:0]  m;
        prod = {64'd0, p.p0} + {32'd0, p.p1, 32'd0} + {32'd0, p.p2, 32'd0} + {p.p3, 64'd0};
        m    = 64'(prod >> sh);
        if (m[63]) begin
            m = 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return p.neg ? $signed(64'd0 - m) : $signed(m);
    endfunction

    // clamp to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // restoring long division, elaboration use only
    function automatic logic [63:0] udiv_c(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int j = 63; j >= 0; j--) begin
            rem = {rem[62:0], n[j]};
            if (rem >= d) begin
                rem  = rem - d;
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q32 turns via series in Q62 radians
    function automatic logic signed [63:0] atan_turn(input int unsigned i);
        logic signed [63:0] sum;
        logic [63:0]        term;
        logic [127:0]       prod;
        if (i == 0) begin
            return 64'sd1 << 29;
        end
        sum = '0;
        for (int unsigned k = 0; i * (2 * k + 1) <= 62; k++) begin
            term = udiv_c(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
            if (k[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        prod = 128'($unsigned(sum)) * 128'(INV2PI_Q64);
        return $signed(64'(prod[127:64] >> 30));
    endfunction

endpackage

// File: sv/spd_cordic.sv
module spd_cordic #(
    parameter int STAGES = spd_pkg::CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [31:0]        i_angle,
    output logic               o_valid,
    output logic signed [32:0] o_cos,
    output logic signed [32:0] o_sin
);

    localparam int XW = 44;
    localparam int ZW = 36;

    // quadrant codes after folding
    localparam logic [1:0] QUAD_E = 2'd0;
    localparam logic [1:0] QUAD_N = 2'd1;
    localparam logic [1:0] QUAD_W = 2'd2;
    localparam logic [1:0] QUAD_S = 2'd3;

    localparam logic signed [XW-1:0] X_START = XW'(spd_pkg::CORDIC_GAIN_INV <<< 10);

    logic signed [XW-1:0] r_x [STAGES+1];
    logic signed [XW-1:0] r_y [STAGES+1];
    logic signed [ZW-1:0] r_z [STAGES+1];
    logic [1:0]           r_q [STAGES+1];
    logic [STAGES:0]      r_vld;

    logic [31:0]          w_sum;
    logic [1:0]           w_q;
    logic [31:0]          w_rr;
    logic signed [32:0]   w_xs;
    logic signed [32:0]   w_ys;

    // fold to nearest quadrant
    assign w_sum = i_angle + 32'h2000_0000;
    assign w_q   = w_sum[31:30];
    assign w_rr  = i_angle - {w_q, 30'd0};

    always_ff @(posedge i_clk) begin
        r_x[0] <= X_START;
        r_y[0] <= '0;
        r_z[0] <= $signed({{(ZW-32){w_rr[31]}}, w_rr});
        r_q[0] <= w_q;
    end

    // one rotation per stage
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAN = ZW'(spd_pkg::atan_turn(i));
        always_ff @(posedge i_clk) begin
            if (r_z[i] >= 0) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - ATAN;
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + ATAN;
            end
            r_q[i+1] <= r_q[i];
        end
    end

    // back to Q30 and unfold the quadrant
    assign w_xs = 33'(r_x[STAGES] >>> 10);
    assign w_ys = 33'(r_y[STAGES] >>> 10);

    always_ff @(posedge i_clk) begin
        case (r_q[STAGES])
            QUAD_E: begin
                o_cos <= w_xs;
                o_sin <= w_ys;
            end
            QUAD_N: begin
                o_cos <= -w_ys;
                o_sin <= w_xs;
            end
            QUAD_W: begin
                o_cos <= -w_xs;
                o_sin <= -w_ys;
            end
            QUAD_S: begin
                o_cos <= w_ys;
                o_sin <= -w_xs;
            end
            default: begin
                o_cos <= w_xs;
                o_sin <= w_ys;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[STAGES-1:0], i_valid};
            o_valid <= r_vld[STAGES];
        end
    end

endmodule

// File: sv/sun_position_from_day.sv
// channel   | signals                   | direction | handshake
// ----------+---------------------------+-----------+---------------------------------
// request   | i_day_number              | in        | start high and busy low
// result    | o_x_au, o_y_au            | out       | o_done high for one cycle
//
// fully pipelined: one request may enter every cycle, busy stays low
// depth comes mostly from two rotation chains in series and the 32-stage restoring divider
// reset clears the valid bits only; the pipeline never stalls, results cannot be held
module sun_position_from_day #(
    parameter int CORDIC_STAGES = spd_pkg::CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_day_number,
    output logic               o_done,
    output logic signed [31:0] o_x_au,
    output logic signed [31:0] o_y_au
);

    localparam int DIV_BITS = 32;

    typedef struct packed {
        logic signed [63:0] m0;
        logic signed [63:0] l0;
        logic signed [63:0] amp;
        logic signed [63:0] bmp;
        logic signed [63:0] e;
        logic signed [63:0] num;
    } t_cy1;

    typedef struct packed {
        logic signed [63:0] e;
        logic signed [63:0] num;
    } t_cy2;

    typedef struct packed {
        logic [33:0]        den;
        logic signed [32:0] cl;
        logic signed [32:0] sl;
    } t_dv;

    logic [10:0] r_vld_f;

    // front end registers
    logic signed [63:0] r_a_d;
    spd_pkg::t_mul_pp   r_b_t;
    logic signed [63:0] r_c_t;
    spd_pkg::t_mul_pp   r_d_t2, r_d_l1, r_d_m1, r_d_a1, r_d_b1, r_d_e2;
    logic signed [63:0] r_d_t;
    logic signed [63:0] r_e_t2, r_e_l1, r_e_m1, r_e_a1, r_e_b1, r_e_e2, r_e_t;
    spd_pkg::t_mul_pp   r_f_t3, r_f_l2, r_f_m2, r_f_a2, r_f_ei;
    logic signed [63:0] r_f_l1, r_f_m1, r_f_a1, r_f_b1;
    logic signed [63:0] r_g_t3, r_g_l2, r_g_m2, r_g_a2, r_g_ei;
    logic signed [63:0] r_g_l1, r_g_m1, r_g_a1, r_g_b1;
    logic signed [63:0] r_h_l0, r_h_amp, r_h_bmp, r_h_e, r_h_m12, r_h_t3;
    spd_pkg::t_mul_pp   r_i_m3, r_i_ee;
    logic signed [63:0] r_i_l0, r_i_amp, r_i_bmp, r_i_e, r_i_m12;
    logic signed [63:0] r_j_m3, r_j_ee;
    logic signed [63:0] r_j_l0, r_j_amp, r_j_bmp, r_j_e, r_j_m12;
    logic signed [63:0] r_k_m0, r_k_l0, r_k_amp, r_k_bmp, r_k_e;
    spd_pkg::t_mul_pp   r_k_num;
    t_cy1               r_l_cy;
    t_cy1               r_dl1 [CORDIC_STAGES+1];

    // equation of centre and longitude stages
    logic               r_m_vld, r_n_vld, r_o_vld;
    spd_pkg::t_mul_pp   r_m_ca, r_m_cb, r_m_c3;
    logic signed [63:0] r_m_m0, r_m_l0, r_m_e, r_m_num;
    logic signed [63:0] r_n_ca, r_n_cb, r_n_c3;
    logic signed [63:0] r_n_m0, r_n_l0, r_n_e, r_n_num;
    logic [31:0]        r_o_v32, r_o_ls32;
    t_cy2               r_o_cy;
    t_cy2               r_dl2 [CORDIC_STAGES+2];

    // distance stages
    logic               r_p_vld, r_q_vld, r_r_vld;
    spd_pkg::t_mul_pp   r_p_ec;
    logic signed [63:0] r_p_num, r_q_num, r_q_ec;
    logic signed [32:0] r_p_cl, r_p_sl, r_q_cl, r_q_sl;
    logic [63:0]        r_r_dvd;
    t_dv                r_r_dv;

    // divider stages
    logic [DIV_BITS-1:0] r_dv_vld;
    logic [33:0]         r_dv_rem [DIV_BITS];
    logic [31:0]         r_dv_q   [DIV_BITS];
    logic [31:0]         r_dv_lo  [DIV_BITS];
    t_dv                 r_dv_cy  [DIV_BITS];

    // output multiply
    logic               r_s_vld;
    spd_pkg::t_mul_pp   r_s_px, r_s_py;

    // sine and cosine results
    logic               w_ca_vld, w_cd_vld;
    logic signed [32:0] w_s1, w_s2, w_s3, w_cv, w_cl, w_sl;
    logic [31:0]        w_m32, w_m32x2, w_m32x3;
    logic signed [63:0] w_cc, w_v, w_ls, w_den;

    assign busy = 1'b0;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_f  <= '0;
            r_m_vld  <= 1'b0;
            r_n_vld  <= 1'b0;
            r_o_vld  <= 1'b0;
            r_p_vld  <= 1'b0;
            r_q_vld  <= 1'b0;
            r_r_vld  <= 1'b0;
            r_dv_vld <= '0;
            r_s_vld  <= 1'b0;
            o_done   <= 1'b0;
        end else begin
            r_vld_f  <= {r_vld_f[9:0], start & ~busy};
            r_m_vld  <= w_ca_vld;
            r_n_vld  <= r_m_vld;
            r_o_vld  <= r_n_vld;
            r_p_vld  <= w_cd_vld;
            r_q_vld  <= r_p_vld;
            r_r_vld  <= r_q_vld;
            r_dv_vld <= {r_dv_vld[DIV_BITS-2:0], r_r_vld};
            r_s_vld  <= r_dv_vld[DIV_BITS-1];
            o_done   <= r_s_vld;
        end
    end

    // centuries, their powers and the polynomial terms
    always_ff @(posedge i_clk) begin
        r_a_d  <= $signed({{32{i_day_number[31]}}, i_day_number}) - spd_pkg::DAY_OFS;
        r_b_t  <= spd_pkg::mul_pp(r_a_d, spd_pkg::K_T);
        r_c_t  <= spd_pkg::mul_fin(r_b_t, 32'd32);

        r_d_t2 <= spd_pkg::mul_pp(r_c_t, r_c_t);
        r_d_l1 <= spd_pkg::mul_pp(spd_pkg::L1C, r_c_t);
        r_d_m1 <= spd_pkg::mul_pp(spd_pkg::M1C, r_c_t);
        r_d_a1 <= spd_pkg::mul_pp(spd_pkg::EQ_A1, r_c_t);
        r_d_b1 <= spd_pkg::mul_pp(spd_pkg::EQ_B1, r_c_t);
        r_d_e2 <= spd_pkg::mul_pp(r_c_t, spd_pkg::ECC2);
        r_d_t  <= r_c_t;

        r_e_t2 <= spd_pkg::mul_fin(r_d_t2, 32'd40);
        r_e_l1 <= spd_pkg::mul_fin(r_d_l1, 32'd40);
        r_e_m1 <= spd_pkg::mul_fin(r_d_m1, 32'd40);
        r_e_a1 <= spd_pkg::mul_fin(r_d_a1, 32'd40);
        r_e_b1 <= spd_pkg::mul_fin(r_d_b1, 32'd40);
        r_e_e2 <= spd_pkg::mul_fin(r_d_e2, 32'd40);
        r_e_t  <= r_d_t;

        r_f_t3 <= spd_pkg::mul_pp(r_e_t, r_e_t2);
        r_f_l2 <= spd_pkg::mul_pp(spd_pkg::L2C, r_e_t2);
        r_f_m2 <= spd_pkg::mul_pp(spd_pkg::M2C, r_e_t2);
        r_f_a2 <= spd_pkg::mul_pp(spd_pkg::EQ_A2, r_e_t2);
        r_f_ei <= spd_pkg::mul_pp(r_e_t, spd_pkg::ECC1 + r_e_e2);
        r_f_l1 <= r_e_l1;
        r_f_m1 <= r_e_m1;
        r_f_a1 <= r_e_a1;
        r_f_b1 <= r_e_b1;

        r_g_t3 <= spd_pkg::mul_fin(r_f_t3, 32'd40);
        r_g_l2 <= spd_pkg::mul_fin(r_f_l2, 32'd40);
        r_g_m2 <= spd_pkg::mul_fin(r_f_m2, 32'd40);
        r_g_a2 <= spd_pkg::mul_fin(r_f_a2, 32'd40);
        r_g_ei <= spd_pkg::mul_fin(r_f_ei, 32'd40);
        r_g_l1 <= r_f_l1;
        r_g_m1 <= r_f_m1;
        r_g_a1 <= r_f_a1;
        r_g_b1 <= r_f_b1;

        r_h_l0  <= spd_pkg::L0C + r_g_l1 + r_g_l2;
        r_h_amp <= spd_pkg::EQ_A0 - r_g_a1 - r_g_a2;
        r_h_bmp <= spd_pkg::EQ_B0 - r_g_b1;
        r_h_e   <= spd_pkg::ECC0 - r_g_ei;
        r_h_m12 <= spd_pkg::M0C + r_g_m1 - r_g_m2;
        r_h_t3  <= r_g_t3;

        r_i_m3  <= spd_pkg::mul_pp(spd_pkg::M3C, r_h_t3);
        r_i_ee  <= spd_pkg::mul_pp(r_h_e, r_h_e);
        r_i_l0  <= r_h_l0;
        r_i_amp <= r_h_amp;
        r_i_bmp <= r_h_bmp;
        r_i_e   <= r_h_e;
        r_i_m12 <= r_h_m12;

        r_j_m3  <= spd_pkg::mul_fin(r_i_m3, 32'd40);
        r_j_ee  <= spd_pkg::mul_fin(r_i_ee, 32'd40);
        r_j_l0  <= r_i_l0;
        r_j_amp <= r_i_amp;
        r_j_bmp <= r_i_bmp;
        r_j_e   <= r_i_e;
        r_j_m12 <= r_i_m12;

        r_k_m0  <= r_j_m12 - r_j_m3;
        r_k_num <= spd_pkg::mul_pp(spd_pkg::SEMI, spd_pkg::ONE40 - r_j_ee);
        r_k_l0  <= r_j_l0;
        r_k_amp <= r_j_amp;
        r_k_bmp <= r_j_bmp;
        r_k_e   <= r_j_e;

        r_l_cy.m0  <= r_k_m0;
        r_l_cy.l0  <= r_k_l0;
        r_l_cy.amp <= r_k_amp;
        r_l_cy.bmp <= r_k_bmp;
        r_l_cy.e   <= r_k_e;
        r_l_cy.num <= (spd_pkg::mul_fin(r_k_num, 32'd40) < 0) ? 64'sd0
                                                             : spd_pkg::mul_fin(r_k_num, 32'd40);
    end

    // mean anomaly and its multiples
    assign w_m32   = r_k_m0[39:8];
    assign w_m32x2 = {w_m32[30:0], 1'b0};
    assign w_m32x3 = w_m32 + w_m32x2;

    spd_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_m1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld_f[10]),
        .i_angle (w_m32),
        .o_valid (w_ca_vld),
        .o_cos   (),
        .o_sin   (w_s1)
    );

    spd_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_m2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld_f[10]),
        .i_angle (w_m32x2),
        .o_valid (),
        .o_cos   (),
        .o_sin   (w_s2)
    );

    spd_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_m3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld_f[10]),
        .i_angle (w_m32x3),
        .o_valid (),
        .o_cos   (),
        .o_sin   (w_s3)
    );

    // carry terms alongside the first rotation chains
    always_ff @(posedge i_clk) begin
        r_dl1[0] <= r_l_cy;
        for (int i = 1; i <= CORDIC_STAGES; i++) begin
            r_dl1[i] <= r_dl1[i-1];
        end
    end

    // equation of centre
    assign w_cc = r_n_ca + r_n_cb + r_n_c3;
    assign w_v  = r_n_m0 + w_cc;
    assign w_ls = r_n_l0 + w_cc;

    always_ff @(posedge i_clk) begin
        r_m_ca  <= spd_pkg::mul_pp(r_dl1[CORDIC_STAGES].amp, 64'(w_s1));
        r_m_cb  <= spd_pkg::mul_pp(r_dl1[CORDIC_STAGES].bmp, 64'(w_s2));
        r_m_c3  <= spd_pkg::mul_pp(spd_pkg::EQ_C0, 64'(w_s3));
        r_m_m0  <= r_dl1[CORDIC_STAGES].m0;
        r_m_l0  <= r_dl1[CORDIC_STAGES].l0;
        r_m_e   <= r_dl1[CORDIC_STAGES].e;
        r_m_num <= r_dl1[CORDIC_STAGES].num;

        r_n_ca  <= spd_pkg::mul_fin(r_m_ca, 32'd30);
        r_n_cb  <= spd_pkg::mul_fin(r_m_cb, 32'd30);
        r_n_c3  <= spd_pkg::mul_fin(r_m_c3, 32'd30);
        r_n_m0  <= r_m_m0;
        r_n_l0  <= r_m_l0;
        r_n_e   <= r_m_e;
        r_n_num <= r_m_num;

        r_o_v32    <= w_v[39:8];
        r_o_ls32   <= w_ls[39:8];
        r_o_cy.e   <= r_n_e;
        r_o_cy.num <= r_n_num;

        r_dl2[0] <= r_o_cy;
        for (int i = 1; i <= CORDIC_STAGES + 1; i++) begin
            r_dl2[i] <= r_dl2[i-1];
        end
    end

    // true anomaly and true longitude
    spd_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_o_vld),
        .i_angle (r_o_v32),
        .o_valid (w_cd_vld),
        .o_cos   (w_cv),
        .o_sin   ()
    );

    spd_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_ls (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_o_vld),
        .i_angle (r_o_ls32),
        .o_valid (),
        .o_cos   (w_cl),
        .o_sin   (w_sl)
    );

    // divisor 1 + e cos v and dividend
    assign w_den = (spd_pkg::ONE40 + r_q_ec) >>> 8;

    always_ff @(posedge i_clk) begin
        r_p_ec  <= spd_pkg::mul_pp(r_dl2[CORDIC_STAGES+1].e, 64'(w_cv));
        r_p_num <= r_dl2[CORDIC_STAGES+1].num;
        r_p_cl  <= w_cl;
        r_p_sl  <= w_sl;

        r_q_ec  <= spd_pkg::mul_fin(r_p_ec, 32'd30);
        r_q_num <= r_p_num;
        r_q_cl  <= r_p_cl;
        r_q_sl  <= r_p_sl;

        r_r_dv.den <= (w_den < 64'sd1) ? 34'd1 : w_den[33:0];
        r_r_dv.cl  <= r_q_cl;
        r_r_dv.sl  <= r_q_sl;
        r_r_dvd    <= {r_q_num[41:0], 22'd0};
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
        logic [33:0] w_rem_in;
        logic [31:0] w_lo_in;
        logic [31:0] w_q_in;
        t_dv         w_cy_in;
        logic [34:0] w_trial;
        logic        w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in = {2'd0, r_r_dvd[63:32]};
            assign w_lo_in  = r_r_dvd[31:0];
            assign w_q_in   = '0;
            assign w_cy_in  = r_r_dv;
        end else begin : g_next
            assign w_rem_in = r_dv_rem[k-1];
            assign w_lo_in  = r_dv_lo[k-1];
            assign w_q_in   = r_dv_q[k-1];
            assign w_cy_in  = r_dv_cy[k-1];
        end

        assign w_trial = {w_rem_in, w_lo_in[31]};
        assign w_ge    = w_trial >= {1'b0, w_cy_in.den};

        always_ff @(posedge i_clk) begin
            r_dv_rem[k] <= w_ge ? 34'(w_trial - {1'b0, w_cy_in.den}) : w_trial[33:0];
            r_dv_q[k]   <= {w_q_in[30:0], w_ge};
            r_dv_lo[k]  <= {w_lo_in[30:0], 1'b0};
            r_dv_cy[k]  <= w_cy_in;
        end
    end

    // x = r cos, y = r sin, then clamp
    always_ff @(posedge i_clk) begin
        r_s_px <= spd_pkg::mul_pp($signed({32'd0, r_dv_q[DIV_BITS-1]}),
                                  64'(r_dv_cy[DIV_BITS-1].cl));
        r_s_py <= spd_pkg::mul_pp($signed({32'd0, r_dv_q[DIV_BITS-1]}),
                                  64'(r_dv_cy[DIV_BITS-1].sl));
        if (r_s_vld) begin
            o_x_au <= spd_pkg::sat32(spd_pkg::mul_fin(r_s_px, 32'd30));
            o_y_au <= spd_pkg::sat32(spd_pkg::mul_fin(r_s_py, 32'd30));
        end
    end

endmodule

// File: sv/spd_check.sv
`include "sun_position_from_day_assert.svh"

module spd_check #(
    parameter int CORDIC_STAGES = spd_pkg::CORDIC_STAGES_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input logic signed [31:0] o_x_au,
    input logic signed [31:0] o_y_au
);

    localparam int LATENCY = 2 * CORDIC_STAGES + 55;

    // the pipeline never holds a request off
    `SPD_ASSERT_NEVER(a_never_busy, busy)

    // every accepted request gives a result after the fixed latency
    `SPD_ASSERT_IMPLY(a_result_follows, start && !busy, ##LATENCY o_done)

    // no result without a request that far back
    `SPD_ASSERT_IMPLY(a_no_spurious, o_done, $past(start && !busy, LATENCY))

    // results are never unknown while strobed
    `SPD_ASSERT_IMPLY(a_known_result, o_done, !$isunknown(o_x_au) && !$isunknown(o_y_au))

endmodule

bind sun_position_from_day spd_check #(.CORDIC_STAGES(CORDIC_STAGES)) u_spd_check (.*);
